// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: assertion helper macros for the scatter unit RTL.
// Taken in by modules that carry assertions; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STDS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STDS_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define STDS_ASSERT(name, clk, rst_n, prop, msg)
`define STDS_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/stds_pkg.sv =====
// stds_pkg: types, codes and config field helpers for the sparse-to-dense scatter unit.
// No dependencies; used by every module of the block.
`default_nettype none
package stds_pkg;

  localparam int MAX_LEVELS  = 8;
  localparam int MAX_RANK    = 4;
  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_BITS  = 32;

  // request opcodes
  localparam logic [1:0] OP_SEG_WR  = 2'd0;
  localparam logic [1:0] OP_IDX_WR  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_VALUE   = 2'd3;

  // config register indexes
  localparam logic [2:0] REG_RANK   = 3'd0;
  localparam logic [2:0] REG_LEVELS = 3'd1;
  localparam logic [2:0] REG_SHAPE  = 3'd2;
  localparam logic [2:0] REG_TRAV   = 3'd3;
  localparam logic [2:0] REG_SPARSE = 3'd4;
  localparam logic [2:0] REG_LSIZE  = 3'd5;
  localparam logic [2:0] REG_BMAP   = 3'd6;
  localparam logic [2:0] REG_BCOUNT = 3'd7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  level;
    logic [7:0]  entry_addr;
    logic [15:0] entry_value;
    logic [31:0] src_value;
  } req_t;

  typedef struct packed {
    logic [63:0] dense_index;
    logic [31:0] element_value;
    logic        exhausted;
  } rsp_t;

  typedef struct packed {
    logic        value;
    logic        restart;
    logic        seg_wr;
    logic        idx_wr;
    logic [2:0]  level;
    logic [7:0]  addr;
    logic [15:0] data;
  } trav_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } trav_rsp_t;

  function automatic logic [2:0] trav_f(logic [23:0] tp, logic [3:0] i);
    logic [2:0] r;
    r = '0;
    if (i < 4'd8) r = tp[3*i[2:0] +: 3];
    return r;
  endfunction

  function automatic logic [7:0] lsize_f(logic [63:0] lp, logic [3:0] i);
    logic [7:0] r;
    r = '0;
    if (i < 4'd8) r = lp[8*i[2:0] +: 8];
    return r;
  endfunction

  function automatic logic [1:0] bmap_f(logic [7:0] bm, logic [2:0] b);
    logic [1:0] r;
    r = '0;
    if (b < 3'd4) r = bm[2*b[1:0] +: 2];
    return r;
  endfunction

  function automatic logic [15:0] dshape_f(logic [63:0] ds, logic [2:0] d);
    logic [15:0] r;
    r = '0;
    if (d < 3'd4) r = ds[16*d[1:0] +: 16];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stds_trav.sv =====
// stds_trav: multi-level CSR iterator with the segment and index tables.
// Depends on stds_pkg. Finds the next leaf in depth-first order, one step a cycle.
`default_nettype none
module stds_trav
  import stds_pkg::*;
#(
  parameter int MaxLevels  = MAX_LEVELS,
  parameter int TableDepth = TABLE_DEPTH,
  localparam int LCW = $clog2(MaxLevels + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  trav_req_t                   req_i,
  input  logic [LCW-1:0]              lc_i,
  input  logic [7:0]                  sparse_i,
  input  logic [63:0]                 lsize_i,
  output trav_rsp_t                   rsp_o,
  output logic [MaxLevels-1:0][15:0]  coord_o
);

  localparam int AW   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int LW   = AW + 1;
  localparam int PW   = (LW > 9) ? LW : 9;
  localparam int LVW  = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;
  localparam int MW   = LVW + AW;
  localparam int CPW  = AW + 10;
  localparam int Psat = TableDepth - 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENTER = 3'd1;
  localparam logic [2:0] S_SEG0  = 3'd2;
  localparam logic [2:0] S_SEG1  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_COORD = 3'd5;

  logic [2:0]     state_q, state_d;
  logic           started_q, started_d;
  logic           done_q, done_d;
  logic [LCW-1:0] lvl_q, lvl_d;
  logic [PW-1:0]  cand_q, cand_d;
  logic [15:0]    lo_q, lo_d;
  trav_rsp_t      rsp_q, rsp_d;

  logic [LW-1:0]  seg_len_q [MaxLevels];
  logic [LW-1:0]  idx_len_q [MaxLevels];
  logic [AW-1:0]  prev_q    [MaxLevels];
  logic [PW-1:0]  pos_q     [MaxLevels];
  logic [PW-1:0]  hi_q      [MaxLevels];
  logic [MaxLevels-1:0][15:0] coord_q;

  logic [15:0] seg_mem [2**MW];
  logic [15:0] idx_mem [2**MW];
  logic [15:0] seg_rd_q, idx_rd_q;

  logic [LVW-1:0] lidx, wl, nl, bl;
  logic [AW-1:0]  cur_p, child_prev;
  logic           cur_sparse, seg_ok, wr_ok, take, at_leaf;
  logic [7:0]     cur_lsize;
  logic [LW-1:0]  pp1, len_new;
  logic [MW-1:0]  waddr, seg_raddr, idx_raddr;
  logic [CPW-1:0] cval;
  logic [PW-1:0]  hi_val, lo_clamp;
  logic [LCW-1:0] lc_m1, lvl_m1;
  logic           enter_hi_we, seg1_we, prev_we;

  assign lidx       = lvl_q[LVW-1:0];
  assign cur_p      = prev_q[lidx];
  assign cur_sparse = sparse_i[lidx];
  assign cur_lsize  = lsize_f(lsize_i, 4'(lidx));
  assign pp1        = LW'(cur_p) + LW'(1);
  assign seg_ok     = (pp1 < seg_len_q[lidx]) && (32'(pp1) < TableDepth);
  assign at_leaf    = (lvl_q == lc_i);
  assign lc_m1      = lc_i - LCW'(1);
  assign lvl_m1     = lvl_q - LCW'(1);
  assign nl         = LVW'(32'(lvl_q) + 1);

  assign wr_ok   = (32'(req_i.level) < MaxLevels) && (32'(req_i.addr) < TableDepth);
  assign wl      = LVW'(req_i.level);
  assign waddr   = {wl, AW'(req_i.addr)};
  assign len_new = LW'(req_i.addr) + LW'(1);

  assign seg_raddr = (state_q == S_SEG0) ? {lidx, AW'(pp1)} : {lidx, cur_p};
  assign idx_raddr = {lidx, AW'(cand_q)};

  // child position handed down; saturates at the last table entry
  assign cval = cur_sparse ? CPW'(cand_q)
                           : CPW'(cur_p) * CPW'(cur_lsize) + CPW'(cand_q);
  assign child_prev = (cval > CPW'(Psat)) ? AW'(Psat) : AW'(cval);

  // sparse range: [seg[p], min(seg[p+1], index length))
  assign hi_val   = (32'(seg_rd_q) > 32'(idx_len_q[lidx])) ? PW'(idx_len_q[lidx])
                                                          : PW'(seg_rd_q);
  assign lo_clamp = (32'(lo_q) < 32'(hi_val)) ? PW'(lo_q) : hi_val;

  assign take        = (state_q == S_CHECK) && (cand_q < hi_q[lidx]);
  assign enter_hi_we = (state_q == S_ENTER) && !at_leaf && !(cur_sparse && seg_ok);
  assign seg1_we     = (state_q == S_SEG1);
  assign prev_we     = take && (32'(lvl_q) + 1 < MaxLevels);
  assign bl          = lc_m1[LVW-1:0];

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    done_d    = done_q;
    lvl_d     = lvl_q;
    cand_d    = cand_q;
    lo_d      = lo_q;
    rsp_d     = '0;
    case (state_q)
      S_IDLE: begin
        if (req_i.restart) begin
          started_d = 1'b0;
          done_d    = 1'b0;
        end else if (req_i.value) begin
          if (done_q) begin
            rsp_d.done = 1'b1;
          end else if (!started_q) begin
            started_d = 1'b1;
            lvl_d     = '0;
            state_d   = S_ENTER;
          end else if (lc_i == '0) begin
            done_d     = 1'b1;
            rsp_d.done = 1'b1;
          end else begin
            lvl_d   = lc_m1;
            cand_d  = pos_q[bl] + PW'(1);
            state_d = S_CHECK;
          end
        end
      end
      S_ENTER: begin
        if (at_leaf) begin
          rsp_d.done  = 1'b1;
          rsp_d.found = 1'b1;
          state_d     = S_IDLE;
        end else if (cur_sparse && seg_ok) begin
          state_d = S_SEG0;
        end else begin
          cand_d  = '0;
          state_d = S_CHECK;
        end
      end
      S_SEG0: begin
        lo_d    = seg_rd_q;
        state_d = S_SEG1;
      end
      S_SEG1: begin
        cand_d  = lo_clamp;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (take) begin
          if (cur_sparse) begin
            state_d = S_COORD;
          end else begin
            lvl_d   = lvl_q + LCW'(1);
            state_d = S_ENTER;
          end
        end else if (lvl_q == '0) begin
          done_d     = 1'b1;
          rsp_d.done = 1'b1;
          state_d    = S_IDLE;
        end else begin
          // backtrack: next sibling one level up
          lvl_d  = lvl_m1;
          cand_d = pos_q[lvl_m1[LVW-1:0]] + PW'(1);
        end
      end
      S_COORD: begin
        lvl_d   = lvl_q + LCW'(1);
        state_d = S_ENTER;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      done_q    <= 1'b0;
      lvl_q     <= '0;
      rsp_q     <= '0;
      for (int k = 0; k < MaxLevels; k++) begin
        seg_len_q[k] <= '0;
        idx_len_q[k] <= '0;
        prev_q[k]    <= '0;
      end
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      done_q    <= done_d;
      lvl_q     <= lvl_d;
      rsp_q     <= rsp_d;
      if (req_i.seg_wr && wr_ok && (seg_len_q[wl] < len_new)) seg_len_q[wl] <= len_new;
      if (req_i.idx_wr && wr_ok && (idx_len_q[wl] < len_new)) idx_len_q[wl] <= len_new;
      if (prev_we) prev_q[nl] <= child_prev;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    lo_q   <= lo_d;
    if (enter_hi_we) hi_q[lidx] <= cur_sparse ? '0 : PW'(cur_lsize);
    if (seg1_we) hi_q[lidx] <= hi_val;
    if (take) pos_q[lidx] <= cand_q;
    if (take && !cur_sparse) coord_q[lidx] <= 16'(cand_q);
    if (state_q == S_COORD) coord_q[lidx] <= idx_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.seg_wr && wr_ok) seg_mem[waddr] <= req_i.data;
    if (req_i.idx_wr && wr_ok) idx_mem[waddr] <= req_i.data;
    seg_rd_q <= seg_mem[seg_raddr];
    idx_rd_q <= idx_mem[idx_raddr];
  end

  assign rsp_o   = rsp_q;
  assign coord_o = coord_q;

endmodule
`default_nettype wire

// ===== hw/rtl/stds_flat.sv =====
// stds_flat: row-major flat index from level coordinates and the block map.
// Depends on stds_pkg. One shared 32x16 multiply-add unit, two passes per 64-bit step.
`default_nettype none
module stds_flat
  import stds_pkg::*;
#(
  parameter int MaxLevels = MAX_LEVELS,
  parameter int MaxRank   = MAX_RANK,
  localparam int LCW = $clog2(MaxLevels + 1),
  localparam int RCW = $clog2(MaxRank + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [LCW-1:0]             lc_i,
  input  logic [RCW-1:0]             rank_i,
  input  logic [2:0]                 bcount_i,
  input  logic [23:0]                trav_i,
  input  logic [7:0]                 bmap_i,
  input  logic [63:0]                lsize_i,
  input  logic [63:0]                shape_i,
  input  logic [MaxLevels-1:0][15:0] coord_i,
  output logic                       done_o,
  output logic [63:0]                index_o
);

  localparam int RW = (MaxRank > 1) ? $clog2(MaxRank) : 1;
  localparam int CW = (LCW > RCW) ? LCW : RCW;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_BLK  = 2'd1;
  localparam logic [1:0] F_HORN = 2'd2;

  logic [1:0]    state_q, state_d;
  logic          half_q, half_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [63:0]   acc_q, acc_d;
  logic [63:0]   idx_q, idx_d;
  logic [63:0]   orig_q    [MaxRank];
  logic [63:0]   orig_init [MaxRank];

  logic [15:0]     cpad [8];
  logic [3:0][7:0] bsz;
  logic [2:0]      t_cur, bi;
  logic [1:0]      d_blk;
  logic            blk_ok, orig_we;
  logic [63:0]     mul_a, mul_c, sum;
  logic [15:0]     mul_b;
  logic [31:0]     a_part;
  logic [47:0]     prod;

  for (genvar k = 0; k < 8; k++) begin : g_pad
    if (k < MaxLevels) begin : g_on
      assign cpad[k] = coord_i[k];
    end else begin : g_off
      assign cpad[k] = '0;
    end
  end

  // block sizes, taken in dimension order as in the block map
  always_comb begin
    logic [2:0] bd;
    logic [2:0] od;
    bd  = '0;
    od  = '0;
    bsz = '0;
    for (int i = 0; i < MaxRank; i++) begin
      if ((i < 32'(rank_i)) && (bd < bcount_i) && (32'(bmap_f(bmap_i, bd)) == i) &&
          (32'(rank_i) + 32'(bd) < 32'(lc_i))) begin
        od = trav_f(trav_i, 4'(32'(rank_i) + 32'(bd)));
        bsz[bd[1:0]] = (32'(od) < 32'(lc_i)) ? lsize_f(lsize_i, 4'(od)) : '0;
        bd = bd + 3'd1;
      end
    end
  end

  // coordinates of the original dimensions; later levels win
  always_comb begin
    logic [2:0] d;
    d = '0;
    for (int j = 0; j < MaxRank; j++) orig_init[j] = '0;
    for (int i = 0; i < MaxRank; i++) begin
      if (i < 32'(rank_i)) begin
        d = trav_f(trav_i, 4'(i));
        if (32'(d) < 32'(rank_i)) begin
          orig_init[RW'(d)] = (i < 32'(lc_i)) ? 64'(cpad[i]) : '0;
        end
      end
    end
  end

  assign t_cur  = trav_f(trav_i, 4'(cnt_q));
  assign bi     = 3'(32'(t_cur) - 32'(rank_i));
  assign d_blk  = bmap_f(bmap_i, bi);
  assign blk_ok = (32'(t_cur) >= 32'(rank_i)) && (bi < bcount_i) &&
                  (32'(d_blk) < 32'(rank_i));

  // shared multiply-add: sum = a * b + c mod 2^64 over two passes
  always_comb begin
    if (state_q == F_HORN) begin
      mul_a = idx_q;
      mul_b = dshape_f(shape_i, 3'(cnt_q));
      mul_c = orig_q[RW'(cnt_q)];
    end else begin
      mul_a = orig_q[RW'(d_blk)];
      mul_b = 16'(bsz[bi[1:0]]);
      mul_c = 64'(cpad[3'(cnt_q)]);
    end
  end

  assign a_part = half_q ? mul_a[63:32] : mul_a[31:0];
  assign prod   = 48'(a_part) * 48'(mul_b);
  assign sum    = half_q ? acc_q + {prod[31:0], 32'd0} : mul_c + 64'(prod);

  always_comb begin
    state_d = state_q;
    half_d  = half_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    orig_we = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          cnt_d   = CW'(rank_i);
          half_d  = 1'b0;
          state_d = F_BLK;
        end
      end
      F_BLK: begin
        if (32'(cnt_q) >= 32'(lc_i)) begin
          idx_d   = (rank_i == '0) ? '0 : orig_q[0];
          cnt_d   = CW'(1);
          state_d = F_HORN;
        end else if (!blk_ok) begin
          cnt_d = cnt_q + CW'(1);
        end else if (!half_q) begin
          acc_d  = sum;
          half_d = 1'b1;
        end else begin
          orig_we = 1'b1;
          half_d  = 1'b0;
          cnt_d   = cnt_q + CW'(1);
        end
      end
      F_HORN: begin
        if (32'(cnt_q) >= 32'(rank_i)) begin
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else if (!half_q) begin
          acc_d  = sum;
          half_d = 1'b1;
        end else begin
          idx_d  = sum;
          half_d = 1'b0;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      half_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      half_q  <= half_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    idx_q <= idx_d;
    if (state_q == F_IDLE && start_i) orig_q <= orig_init;
    if (orig_we) orig_q[RW'(d_blk)] <= sum;
  end

  assign done_o  = done_q;
  assign index_o = idx_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sparse_tensor_to_dense_scatter_unit.sv =====
// sparse_tensor_to_dense_scatter_unit: top level, config registers and request control.
// Depends on stds_pkg, stds_trav, stds_flat and assert_macros.svh.
//
//  port group          dir  handshake                     payload
//  request             in   start && !busy                req_i (req_t)
//  result              out  result_valid_o, one cycle     result_o (rsp_t)
//  config              in   cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// Table writes and restarts leave busy low.
// A value request steps through each level entered (a sparse level adds table reads)
// and each backtrack step, then through the levels past the rank (a block level over
// both halves) and the rank dimensions in the shared multiply-add; the result is registered.
// Reset clears control and table lengths; table contents stay undefined until written.
// The receiver cannot stall; a new request may be taken in the cycle a result shows.
`default_nettype none
`include "assert_macros.svh"
module sparse_tensor_to_dense_scatter_unit
  import stds_pkg::*;
#(
  parameter int MaxLevels  = MAX_LEVELS,
  parameter int MaxRank    = MAX_RANK,
  parameter int TableDepth = TABLE_DEPTH,
  parameter int ValueBits  = VALUE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        result_valid_o,
  output rsp_t        result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int LCW = $clog2(MaxLevels + 1);
  localparam int RCW = $clog2(MaxRank + 1);
  localparam logic [31:0] ValMask = (ValueBits >= 32) ? 32'hFFFF_FFFF
                                                      : 32'((64'd1 << ValueBits) - 64'd1);

  logic [2:0]  rank_q;
  logic [3:0]  levels_q;
  logic [63:0] shape_q;
  logic [23:0] trav_q;
  logic [7:0]  sparse_q;
  logic [63:0] lsize_q;
  logic [7:0]  bmap_q;
  logic [2:0]  bcount_q;

  logic        busy_q, busy_d;
  logic [31:0] val_q;
  logic        res_valid_q, res_valid_d;
  rsp_t        res_q, res_d;

  logic           accept, f_done;
  logic [LCW-1:0] eff_lc;
  logic [RCW-1:0] eff_rank;
  logic [2:0]     eff_bc;
  logic [63:0]    f_index;
  trav_req_t      t_req;
  trav_rsp_t      t_rsp;
  logic [MaxLevels-1:0][15:0] coord;

  assign accept = start && !busy_q;

  assign eff_lc   = (32'(levels_q) > MaxLevels) ? LCW'(MaxLevels) : LCW'(levels_q);
  assign eff_rank = (32'(rank_q) > MaxRank) ? RCW'(MaxRank) : RCW'(rank_q);
  assign eff_bc   = (bcount_q > 3'd4) ? 3'd4 : bcount_q;

  always_comb begin
    t_req         = '0;
    t_req.value   = accept && (req_i.opcode == OP_VALUE);
    t_req.restart = (accept && (req_i.opcode != OP_VALUE)) || cfg_we_i;
    t_req.seg_wr  = accept && (req_i.opcode == OP_SEG_WR);
    t_req.idx_wr  = accept && (req_i.opcode == OP_IDX_WR);
    t_req.level   = req_i.level;
    t_req.addr    = req_i.entry_addr;
    t_req.data    = req_i.entry_value;
  end

  stds_trav #(
    .MaxLevels  (MaxLevels),
    .TableDepth (TableDepth)
  ) u_trav (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (t_req),
    .lc_i     (eff_lc),
    .sparse_i (sparse_q),
    .lsize_i  (lsize_q),
    .rsp_o    (t_rsp),
    .coord_o  (coord)
  );

  stds_flat #(
    .MaxLevels (MaxLevels),
    .MaxRank   (MaxRank)
  ) u_flat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (t_rsp.done && t_rsp.found),
    .lc_i     (eff_lc),
    .rank_i   (eff_rank),
    .bcount_i (eff_bc),
    .trav_i   (trav_q),
    .bmap_i   (bmap_q),
    .lsize_i  (lsize_q),
    .shape_i  (shape_q),
    .coord_i  (coord),
    .done_o   (f_done),
    .index_o  (f_index)
  );

  always_comb begin
    busy_d      = busy_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (accept && (req_i.opcode == OP_VALUE)) busy_d = 1'b1;
    if (f_done) begin
      res_valid_d         = 1'b1;
      res_d.dense_index   = f_index;
      res_d.element_value = val_q & ValMask;
      res_d.exhausted     = 1'b0;
      busy_d              = 1'b0;
    end else if (t_rsp.done && !t_rsp.found) begin
      res_valid_d         = 1'b1;
      res_d.dense_index   = '0;
      res_d.element_value = '0;
      res_d.exhausted     = 1'b1;
      busy_d              = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q      <= 3'd1;
      levels_q    <= 4'd1;
      shape_q     <= '0;
      trav_q      <= '0;
      sparse_q    <= '0;
      lsize_q     <= '0;
      bmap_q      <= '0;
      bcount_q    <= '0;
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RANK:   rank_q   <= cfg_wdata_i[2:0];
          REG_LEVELS: levels_q <= cfg_wdata_i[3:0];
          REG_SHAPE:  shape_q  <= cfg_wdata_i;
          REG_TRAV:   trav_q   <= cfg_wdata_i[23:0];
          REG_SPARSE: sparse_q <= cfg_wdata_i[7:0];
          REG_LSIZE:  lsize_q  <= cfg_wdata_i;
          REG_BMAP:   bmap_q   <= cfg_wdata_i[7:0];
          REG_BCOUNT: bcount_q <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept && (req_i.opcode == OP_VALUE)) val_q <= req_i.src_value;
  end

  assign busy           = busy_q;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `STDS_ASSERT(a_idle_on_result, clk_i, rst_ni, result_valid_o |-> !busy, "result while busy")
  `STDS_ASSERT(a_busy_ends_in_result, clk_i, rst_ni, $fell(busy) |-> result_valid_o, "busy dropped without result")
  `STDS_ASSERT(a_exhausted_empty, clk_i, rst_ni, (result_valid_o && result_o.exhausted) |-> (result_o.dense_index == 64'd0 && result_o.element_value == 32'd0), "exhausted result carries data")
  `STDS_NEVER(a_one_finisher, clk_i, rst_ni, t_rsp.done && f_done, "iterator and index unit finished together")

endmodule
`default_nettype wire
